[rtl/core/odr_pkg.sv]
// odr_pkg: shared widths, constants, command types and the cordic arctangent table
// for the odometer dead reckoning block; no dependencies
package odr_pkg;

  localparam int TICK_BITS  = 16;
  localparam int DPC_W      = 24;
  localparam int TR_W       = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int DIST_W     = 56;
  localparam int NUM_W      = DIST_W + TR_W;
  localparam int DIV_N      = 31;
  localparam int CORDIC_N   = 16;
  localparam int CNT_W      = 5;
  localparam int Z_W        = 21;
  localparam int XY_W       = 34;

  localparam logic [CFG_IDX_W-1:0] CFG_DPC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TR  = 2'd1;

  localparam logic [DPC_W-1:0] DPC_RESET = 24'd13107;
  localparam logic [TR_W-1:0]  TR_RESET  = 20'd21736;

  localparam logic signed [Z_W-1:0]  PI_Q16      = 21'sd205887;
  localparam logic signed [Z_W-1:0]  HALF_PI_Q16 = 21'sd102944;
  localparam logic signed [XY_W-1:0] CORDIC_K30  = 34'sd652032874;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_DIST, MUL_NLO, MUL_NHI, MUL_PXL, MUL_PXH,
    MUL_PYL, MUL_PYH, MUL_VX, MUL_VY
  } mul_op_t;

  typedef struct packed {
    logic       capture;
    mul_op_t    mul;
    logic       div_init;
    logic       iter_step;
    logic       cordic_en;
    logic [3:0] cordic_idx;
    logic       finish;
    logic       apply;
    logic       load_out;
  } odr_cmd_t;

  typedef struct packed {
    logic act;
  } odr_sts_t;

  function automatic logic [15:0] atan_q16(input logic [3:0] idx);
    logic [15:0] v;
    case (idx)
      4'd0:    v = 16'd51472;
      4'd1:    v = 16'd30386;
      4'd2:    v = 16'd16055;
      4'd3:    v = 16'd8150;
      4'd4:    v = 16'd4091;
      4'd5:    v = 16'd2047;
      4'd6:    v = 16'd1024;
      4'd7:    v = 16'd512;
      4'd8:    v = 16'd256;
      4'd9:    v = 16'd128;
      4'd10:   v = 16'd64;
      4'd11:   v = 16'd32;
      4'd12:   v = 16'd16;
      4'd13:   v = 16'd8;
      4'd14:   v = 16'd4;
      default: v = 16'd2;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/odr_if.sv]
// odr_if: valid/ready stream interfaces for odometer reports and dead reckoning results
// no dependencies
interface odr_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        timestamp;
  logic [15:0]        tick;
  logic [31:0]        pulse_count;
  logic signed [15:0] heading;
  logic               heading_valid;
  modport source(output valid, timestamp, tick, pulse_count, heading, heading_valid,
                 input ready);
  modport sink(input valid, timestamp, tick, pulse_count, heading, heading_valid,
               output ready);
endinterface

interface odr_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] position_x;
  logic signed [47:0] position_y;
  logic signed [31:0] velocity_x;
  logic signed [31:0] velocity_y;
  logic               moved;
  modport source(output valid, position_x, position_y, velocity_x, velocity_y, moved,
                 input ready);
  modport sink(input valid, position_x, position_y, velocity_x, velocity_y, moved,
               output ready);
endinterface

[rtl/core/odr_ctrl.sv]
// odr_ctrl: sequencer for the dead reckoning datapath and output handshake
// depends on odr_pkg
module odr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  odr_pkg::odr_sts_t sts,
  output odr_pkg::odr_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIST, ST_DWB, ST_NLO, ST_NHI, ST_NWB, ST_DINIT, ST_ITER, ST_CS,
    ST_PXL, ST_PXH, ST_PYL, ST_PYH, ST_VX, ST_VY, ST_APPLY, ST_FIN
  } state_t;

  localparam logic [odr_pkg::CNT_W-1:0] ITER_LAST = odr_pkg::CNT_W'(odr_pkg::DIV_N - 1);
  localparam logic [odr_pkg::CNT_W-1:0] CORDIC_CNT = odr_pkg::CNT_W'(odr_pkg::CORDIC_N);

  state_t                     st_r;
  logic [odr_pkg::CNT_W-1:0]  cnt_r;
  logic                       out_valid_r;

  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd            = '0;
    cmd.mul        = odr_pkg::MUL_NONE;
    cmd.cordic_idx = cnt_r[3:0];
    case (st_r)
      ST_IDLE:  cmd.capture = in_valid;
      ST_DIST:  cmd.mul = odr_pkg::MUL_DIST;
      ST_NLO:   cmd.mul = odr_pkg::MUL_NLO;
      ST_NHI:   cmd.mul = odr_pkg::MUL_NHI;
      ST_DINIT: cmd.div_init = 1'b1;
      ST_ITER: begin
        cmd.iter_step = 1'b1;
        cmd.cordic_en = (cnt_r < CORDIC_CNT);
      end
      ST_CS:    cmd.finish = 1'b1;
      ST_PXL:   cmd.mul = odr_pkg::MUL_PXL;
      ST_PXH:   cmd.mul = odr_pkg::MUL_PXH;
      ST_PYL:   cmd.mul = odr_pkg::MUL_PYL;
      ST_PYH:   cmd.mul = odr_pkg::MUL_PYH;
      ST_VX:    cmd.mul = odr_pkg::MUL_VX;
      ST_VY:    cmd.mul = odr_pkg::MUL_VY;
      ST_APPLY: cmd.apply = 1'b1;
      ST_FIN:   cmd.load_out = !out_valid_r || out_ready;
      default:  cmd.capture = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE:  if (in_valid) st_r <= ST_DIST;
        ST_DIST:  st_r <= sts.act ? ST_DWB : ST_FIN;
        ST_DWB:   st_r <= ST_NLO;
        ST_NLO:   st_r <= ST_NHI;
        ST_NHI:   st_r <= ST_NWB;
        ST_NWB:   st_r <= ST_DINIT;
        ST_DINIT: begin
          cnt_r <= '0;
          st_r  <= ST_ITER;
        end
        ST_ITER: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == ITER_LAST) st_r <= ST_CS;
        end
        ST_CS:    st_r <= ST_PXL;
        ST_PXL:   st_r <= ST_PXH;
        ST_PXH:   st_r <= ST_PYL;
        ST_PYL:   st_r <= ST_PYH;
        ST_PYH:   st_r <= ST_VX;
        ST_VX:    st_r <= ST_VY;
        ST_VY:    st_r <= ST_APPLY;
        ST_APPLY: st_r <= ST_FIN;
        ST_FIN:   if (cmd.load_out) st_r <= ST_IDLE;
        default:  st_r <= ST_IDLE;
      endcase
    end
  end

  a_iter_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ITER && cnt_r == ITER_LAST) |=> (st_r == ST_CS))
    else $error("iteration run did not end in finish step");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result load did not raise out valid");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (st_r == ST_DIST))
    else $error("accepted transaction did not start processing");

  a_no_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (st_r == ST_IDLE))
    else $error("capture outside idle");

endmodule

[rtl/core/odr_datapath.sv]
// odr_datapath: configuration registers, track state, shared multiplier,
// cordic and restoring divider for dead reckoning; depends on odr_pkg
module odr_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [odr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [odr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [31:0]                      in_timestamp,
  input  logic [15:0]                      in_tick,
  input  logic [31:0]                      in_pulse_count,
  input  logic signed [15:0]               in_heading,
  input  logic                             in_heading_valid,
  input  odr_pkg::odr_cmd_t                cmd,
  output odr_pkg::odr_sts_t                sts,
  output logic signed [47:0]               out_position_x,
  output logic signed [47:0]               out_position_y,
  output logic signed [31:0]               out_velocity_x,
  output logic signed [31:0]               out_velocity_y,
  output logic                             out_moved
);

  localparam int TB = odr_pkg::TICK_BITS;

  // configuration and track state
  logic [odr_pkg::DPC_W-1:0] dpc_r;
  logic [odr_pkg::TR_W-1:0]  tr_r;
  logic [31:0]               last_count_r;
  logic [TB-1:0]             last_tick_r;
  logic                      seen_r;
  logic [31:0]               last_stamp_r;
  logic signed [47:0]        pos_x_r, pos_y_r;
  logic signed [31:0]        vel_x_r, vel_y_r;
  odr_pkg::mul_op_t          tag_r;

  // working registers
  logic                            act_r;
  logic [31:0]                     cdiff_r;
  logic [TB-1:0]                   ticks_r;
  logic [odr_pkg::DIST_W-1:0]      dist_r;
  logic [odr_pkg::NUM_W-1:0]       num_r;
  logic [55:0]                     prod_r;
  logic [63:0]                     accx_r, accy_r;
  logic signed [odr_pkg::XY_W-1:0] x_r, y_r;
  logic signed [odr_pkg::Z_W-1:0]  z_r;
  logic                            rneg_r;
  logic [TB-1:0]                   rem_r;
  logic [odr_pkg::DIV_N-1:0]       nq_r, q_r;
  logic                            ovf_r;
  logic [16:0]                     cmag_r, smag_r;
  logic                            cneg_r, sneg_r;
  logic [31:0]                     speed_r;
  logic signed [47:0]              opx_r, opy_r;
  logic signed [31:0]              ovx_r, ovy_r;
  logic                            omv_r;

  assign sts.act        = act_r;
  assign out_position_x = opx_r;
  assign out_position_y = opy_r;
  assign out_velocity_x = ovx_r;
  assign out_velocity_y = ovy_r;
  assign out_moved      = omv_r;

  // capture logic
  logic                   changed, gate;
  logic [TB-1:0]          tick_in;
  logic signed [odr_pkg::Z_W-1:0] zh;

  assign tick_in = in_tick[TB-1:0];
  assign changed = (in_timestamp != last_stamp_r);
  assign gate    = seen_r && (last_tick_r != '0) && changed;
  assign zh      = {{2{in_heading[15]}}, in_heading, 3'b000};

  // shared multiplier
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [46:0] dpos;

  assign dpos = (dist_r > odr_pkg::DIST_W'(47'h7FFF_FFFF_FFFF)) ? 47'h7FFF_FFFF_FFFF
                                                                : dist_r[46:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul)
      odr_pkg::MUL_DIST: begin
        mul_a = cdiff_r;
        mul_b = dpc_r;
      end
      odr_pkg::MUL_NLO: begin
        mul_a = {4'b0, dist_r[27:0]};
        mul_b = {4'b0, tr_r};
      end
      odr_pkg::MUL_NHI: begin
        mul_a = {4'b0, dist_r[55:28]};
        mul_b = {4'b0, tr_r};
      end
      odr_pkg::MUL_PXL: begin
        mul_a = {8'b0, dpos[23:0]};
        mul_b = {7'b0, cmag_r};
      end
      odr_pkg::MUL_PXH: begin
        mul_a = {9'b0, dpos[46:24]};
        mul_b = {7'b0, cmag_r};
      end
      odr_pkg::MUL_PYL: begin
        mul_a = {8'b0, dpos[23:0]};
        mul_b = {7'b0, smag_r};
      end
      odr_pkg::MUL_PYH: begin
        mul_a = {9'b0, dpos[46:24]};
        mul_b = {7'b0, smag_r};
      end
      odr_pkg::MUL_VX: begin
        mul_a = speed_r;
        mul_b = {7'b0, cmag_r};
      end
      odr_pkg::MUL_VY: begin
        mul_a = speed_r;
        mul_b = {7'b0, smag_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // velocity from registered product
  logic [32:0]        vmag;
  logic signed [31:0] vel_new;
  logic               vneg;

  assign vmag = prod_r[48:16];
  assign vneg = (tag_r == odr_pkg::MUL_VX) ? cneg_r : sneg_r;

  always_comb begin
    if (vneg) begin
      vel_new = 32'(-$signed({1'b0, vmag}));
    end else if (vmag > 33'h0_7FFF_FFFF) begin
      vel_new = 32'sh7FFF_FFFF;
    end else begin
      vel_new = vmag[31:0];
    end
  end

  // position update with saturation
  function automatic logic signed [47:0] pos_add(input logic signed [47:0] p,
                                                 input logic [63:0] acc,
                                                 input logic neg);
    logic signed [48:0] stp;
    logic signed [48:0] sum;
    stp = $signed({1'b0, acc[63:16]});
    sum = {p[47], p} + (neg ? -stp : stp);
    if (sum[48] != sum[47]) begin
      return sum[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end
    return sum[47:0];
  endfunction

  // cordic finish: round, clamp, undo half-turn
  function automatic logic [17:0] cs_fin(input logic signed [odr_pkg::XY_W-1:0] v,
                                         input logic neg);
    logic signed [odr_pkg::XY_W:0] r;
    logic signed [17:0]            cl;
    r = ($signed({v[odr_pkg::XY_W-1], v}) + 35'sd8192) >>> 14;
    if (r > 35'sd65536) begin
      cl = 18'sd65536;
    end else if (r < -35'sd65536) begin
      cl = -18'sd65536;
    end else begin
      cl = r[17:0];
    end
    return neg ? -cl : cl;
  endfunction

  logic signed [17:0] cfin, sfin;
  assign cfin = cs_fin(x_r, rneg_r);
  assign sfin = cs_fin(y_r, rneg_r);

  // divider step
  logic [TB:0]   dtrial;
  logic          dge;
  assign dtrial = {rem_r, nq_r[odr_pkg::DIV_N-1]};
  assign dge    = (dtrial >= {1'b0, ticks_r});

  // cordic step
  logic signed [odr_pkg::XY_W-1:0] xs, ys;
  logic signed [odr_pkg::Z_W-1:0]  at;
  assign xs = x_r >>> cmd.cordic_idx;
  assign ys = y_r >>> cmd.cordic_idx;
  assign at = $signed({5'b0, odr_pkg::atan_q16(cmd.cordic_idx)});

  logic [44:0] nhi;
  assign nhi = num_r[odr_pkg::NUM_W-1:odr_pkg::DIV_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpc_r        <= odr_pkg::DPC_RESET;
      tr_r         <= odr_pkg::TR_RESET;
      last_count_r <= '0;
      last_tick_r  <= '0;
      seen_r       <= 1'b0;
      last_stamp_r <= '0;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      vel_x_r      <= '0;
      vel_y_r      <= '0;
      tag_r        <= odr_pkg::MUL_NONE;
      act_r        <= 1'b0;
    end else begin
      tag_r <= cmd.mul;
      if (cfg_we) begin
        case (cfg_index)
          odr_pkg::CFG_DPC: dpc_r <= cfg_data;
          odr_pkg::CFG_TR:  tr_r  <= cfg_data[odr_pkg::TR_W-1:0];
          default:          dpc_r <= dpc_r;
        endcase
      end
      if (cmd.capture) begin
        act_r        <= in_heading_valid && changed;
        last_count_r <= in_pulse_count;
        last_tick_r  <= tick_in;
        seen_r       <= 1'b1;
        last_stamp_r <= in_timestamp;
      end
      if ((tag_r == odr_pkg::MUL_VX) && (ticks_r != '0)) vel_x_r <= vel_new;
      if ((tag_r == odr_pkg::MUL_VY) && (ticks_r != '0)) vel_y_r <= vel_new;
      if (cmd.apply) begin
        pos_x_r <= pos_add(pos_x_r, accx_r, cneg_r);
        pos_y_r <= pos_add(pos_y_r, accy_r, sneg_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.capture) begin
      cdiff_r <= gate ? (in_pulse_count - last_count_r) : '0;
      ticks_r <= gate ? (tick_in - last_tick_r) : '0;
      x_r     <= odr_pkg::CORDIC_K30;
      y_r     <= '0;
      if (zh > odr_pkg::HALF_PI_Q16) begin
        z_r    <= zh - odr_pkg::PI_Q16;
        rneg_r <= 1'b1;
      end else if (zh < -odr_pkg::HALF_PI_Q16) begin
        z_r    <= zh + odr_pkg::PI_Q16;
        rneg_r <= 1'b1;
      end else begin
        z_r    <= zh;
        rneg_r <= 1'b0;
      end
    end
    case (tag_r)
      odr_pkg::MUL_DIST: dist_r <= prod_r;
      odr_pkg::MUL_NLO:  num_r  <= {28'b0, prod_r[47:0]};
      odr_pkg::MUL_NHI:  num_r  <= num_r + {prod_r[47:0], 28'b0};
      odr_pkg::MUL_PXL:  accx_r <= {8'b0, prod_r};
      odr_pkg::MUL_PXH:  accx_r <= accx_r + {prod_r[39:0], 24'b0};
      odr_pkg::MUL_PYL:  accy_r <= {8'b0, prod_r};
      odr_pkg::MUL_PYH:  accy_r <= accy_r + {prod_r[39:0], 24'b0};
      default:           dist_r <= dist_r;
    endcase
    if (cmd.div_init) begin
      ovf_r <= (nhi >= {{(45-TB){1'b0}}, ticks_r});
      rem_r <= nhi[TB-1:0];
      nq_r  <= num_r[odr_pkg::DIV_N-1:0];
      q_r   <= '0;
    end
    if (cmd.iter_step) begin
      rem_r <= dge ? TB'(dtrial - {1'b0, ticks_r}) : dtrial[TB-1:0];
      q_r   <= {q_r[odr_pkg::DIV_N-2:0], dge};
      nq_r  <= {nq_r[odr_pkg::DIV_N-2:0], 1'b0};
    end
    if (cmd.cordic_en) begin
      if (z_r >= 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
    if (cmd.finish) begin
      cmag_r <= cfin[17] ? 17'(-cfin) : cfin[16:0];
      cneg_r <= cfin[17];
      smag_r <= sfin[17] ? 17'(-sfin) : sfin[16:0];
      sneg_r <= sfin[17];
      if (tr_r == '0) begin
        speed_r <= '0;
      end else if (ovf_r) begin
        speed_r <= 32'h8000_0000;
      end else begin
        speed_r <= {1'b0, q_r};
      end
    end
    if (cmd.load_out) begin
      opx_r <= pos_x_r;
      opy_r <= pos_y_r;
      ovx_r <= vel_x_r;
      ovy_r <= vel_y_r;
      omv_r <= act_r;
    end
  end

endmodule

[rtl/core/odometer_dead_reckoning.sv]
// odometer_dead_reckoning: top level, one result transaction per odometer report
// with a valid heading and a changed stamp the result waits on the 31-step divider run;
// otherwise the sequencer goes straight from the distance step to the output load
// one report at a time: the next input is taken in the cycle after the result is
// loaded into the output register;
// sync active-low reset clears track state, config returns to its reset values
module odometer_dead_reckoning (
  input  logic                           clk,
  input  logic                           rst_n,
  odr_in_if.sink                         in_ch,
  odr_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [odr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [odr_pkg::CFG_DATA_W-1:0] cfg_data
);

  // command and status between sequencer and datapath
  odr_pkg::odr_cmd_t cmd;
  odr_pkg::odr_sts_t sts;

  // sequencer: capture, multiplier schedule, divider and cordic run, output load
  odr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: config, track state, shared multiplier, cordic, divider, output register
  odr_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_timestamp     (in_ch.timestamp),
    .in_tick          (in_ch.tick),
    .in_pulse_count   (in_ch.pulse_count),
    .in_heading       (in_ch.heading),
    .in_heading_valid (in_ch.heading_valid),
    .cmd              (cmd),
    .sts              (sts),
    .out_position_x   (out_ch.position_x),
    .out_position_y   (out_ch.position_y),
    .out_velocity_x   (out_ch.velocity_x),
    .out_velocity_y   (out_ch.velocity_y),
    .out_moved        (out_ch.moved)
  );

endmodule

[sim/tb.sv]
// tb: self-checking testbench for odometer_dead_reckoning, with directed and random
// odometer reports, random stalls on both channels and config changes between phases
// depends on odr_pkg, odr_in_if, odr_out_if and the rtl top level
`timescale 1ns / 100ps

module tb;

  // one odometer report as driven on the input channel
  typedef struct {
    logic [31:0]        stamp;
    logic [15:0]        tick;
    logic [31:0]        count;
    logic signed [15:0] heading;
    logic               hvalid;
  } report_t;

  // one dead reckoning result as seen on the output channel
  typedef struct {
    logic [47:0] px;
    logic [47:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic        moved;
  } track_t;

  localparam longint POS_HI = 64'sd140737488355327;
  localparam longint POS_LO = -64'sd140737488355328;
  localparam longint VEL_HI = 64'sd2147483647;
  localparam longint VEL_LO = -64'sd2147483648;
  localparam longint HALF_TURN = 205887;
  localparam longint QUARTER_TURN = 102944;
  localparam longint GAIN_Q30 = 652032874;
  localparam int     DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [odr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [odr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  odr_in_if  in_bus ();
  odr_out_if out_bus ();

  odometer_dead_reckoning uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // stimulus and scoreboard state
  report_t pending_reports[$];
  track_t  expected_tracks[$];
  bit      hold_sender = 1'b0;   // sender pauses while set
  bit      idle_on = 1'b1;       // random gaps and stalls enabled
  bit      in_took = 1'b0;       // input transaction seen at the last rising edge
  int      in_gap = 0;
  int      mismatches = 0;
  int      unexpected = 0;

  // predictor state: configuration copy and dead reckoning track
  logic [23:0] dpc_q = odr_pkg::DPC_RESET;
  logic [19:0] rate_q = odr_pkg::TR_RESET;
  logic [31:0] prev_count = '0;
  logic [15:0] prev_tick = '0;
  bit          have_tick = 1'b0;
  logic [31:0] prev_stamp = '0;
  longint      east = 0, north = 0, v_east = 0, v_north = 0;

  // random-sequence generator state
  logic [31:0] seq_stamp = 32'd1;
  logic [15:0] seq_tick = 16'd100;
  logic [31:0] seq_count = '0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint arctan_step(int i);
    longint tbl[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2};
    return tbl[i];
  endfunction

  // 16-step rotation on Q.30, result rounded to Q.16
  function automatic void rotate_heading(input logic signed [15:0] hd,
                                         output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = longint'(hd) * 8;
    x = GAIN_Q30;
    y = 0;
    flip = 1'b0;
    if (z > QUARTER_TURN) begin
      z -= HALF_TURN;
      flip = 1'b1;
    end else if (z < -QUARTER_TURN) begin
      z += HALF_TURN;
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_step(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_step(i);
      end
      x = nx;
    end
    x = clip((x + 8192) >>> 14, -65536, 65536);
    y = clip((y + 8192) >>> 14, -65536, 65536);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // sign(t) * floor(mag * |t| / 2^16)
  function automatic longint scale_by(bit [63:0] mag, longint t);
    bit [63:0] a, r;
    a = (t < 0) ? 64'(-t) : 64'(t);
    r = (mag * a) >> 16;
    return (t < 0) ? -longint'(r) : longint'(r);
  endfunction

  // advances the track by one report and queues the result it should produce
  function automatic void advance_track(report_t rp);
    bit [63:0] step_len, ticks, q, r, speed, dpos;
    bit changed, moved;
    longint c, s;
    track_t t;
    changed = (rp.stamp != prev_stamp);
    step_len = 0;
    ticks = 0;
    moved = 1'b0;
    if (have_tick && prev_tick != 0 && changed) begin
      step_len = 64'(32'(rp.count - prev_count)) * 64'(dpc_q);
      ticks = 64'(16'(rp.tick - prev_tick));
    end
    prev_tick = rp.tick;
    have_tick = 1'b1;
    prev_count = rp.count;
    if (rp.hvalid && changed) begin
      dpos = (step_len > 64'(POS_HI)) ? 64'(POS_HI) : step_len;
      rotate_heading(rp.heading, c, s);
      east = clip(east + scale_by(dpos, c), POS_LO, POS_HI);
      north = clip(north + scale_by(dpos, s), POS_LO, POS_HI);
      moved = 1'b1;
      if (ticks > 0) begin
        q = step_len / ticks;
        r = step_len % ticks;
        if (rate_q == 0) speed = 0;
        else if (q >= 64'h1_0000_0000) speed = 64'h8000_0000;
        else speed = q * rate_q + (r * rate_q) / ticks;
        if (speed > 64'h8000_0000) speed = 64'h8000_0000;
        v_east = clip(scale_by(speed, c), VEL_LO, VEL_HI);
        v_north = clip(scale_by(speed, s), VEL_LO, VEL_HI);
      end
    end
    prev_stamp = rp.stamp;
    t.px = east[47:0];
    t.py = north[47:0];
    t.vx = v_east[31:0];
    t.vy = v_north[31:0];
    t.moved = moved;
    expected_tracks.push_back(t);
  endfunction

  // mostly well-formed report streams, the rest noise
  function automatic report_t random_report();
    report_t rp;
    int k;
    k = $urandom_range(0, 99);
    if (k < 80) begin
      seq_stamp += $urandom_range(1, 5);
      if ($urandom_range(0, 9) == 0) seq_tick = $urandom;
      else seq_tick += $urandom_range(1, 3000);
      case ($urandom_range(0, 19))
        0, 1:    seq_count = $urandom;
        2:       seq_count -= $urandom_range(1, 50);
        default: seq_count += $urandom_range(0, 2000);
      endcase
      rp.stamp = seq_stamp;
      rp.tick = seq_tick;
      rp.count = seq_count;
      if ($urandom_range(0, 9) == 0) rp.heading = $urandom;
      else rp.heading = $signed($urandom_range(0, 51472)) - 25736;
      rp.hvalid = ($urandom_range(0, 9) != 0);
    end else begin
      rp.stamp = ($urandom_range(0, 1) == 0) ? seq_stamp : $urandom;
      rp.tick = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
      rp.count = $urandom;
      rp.heading = $urandom;
      rp.hvalid = $urandom_range(0, 1);
    end
    return rp;
  endfunction

  // input driver: changes at the falling edge, holds until the transaction is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_took) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_bus.valid <= 1'b0;
      end else if (!hold_sender && pending_reports.size() > 0) begin
        report_t rp;
        rp = pending_reports.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.timestamp <= rp.stamp;
        in_bus.tick <= rp.tick;
        in_bus.pulse_count <= rp.count;
        in_bus.heading <= rp.heading;
        in_bus.heading_valid <= rp.hvalid;
        in_gap <= gap_len();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // result receiver stalls
  always @(negedge clk) begin
    if (!rst_n) out_bus.ready <= 1'b0;
    else out_bus.ready <= (gap_len() == 0);
  end

  // monitor: predicts on input transactions, checks output transactions
  always @(posedge clk) begin
    in_took <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      report_t rp;
      rp.stamp = in_bus.timestamp;
      rp.tick = in_bus.tick;
      rp.count = in_bus.pulse_count;
      rp.heading = in_bus.heading;
      rp.hvalid = in_bus.heading_valid;
      advance_track(rp);
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_tracks.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected result transaction at %0t", $time);
      end else begin
        track_t e;
        e = expected_tracks.pop_front();
        if (out_bus.position_x !== e.px || out_bus.position_y !== e.py ||
            out_bus.velocity_x !== e.vx || out_bus.velocity_y !== e.vy ||
            out_bus.moved !== e.moved) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display({"mismatch at %0t: exp px=%h py=%h vx=%h vy=%h mv=%b, ",
                      "got px=%h py=%h vx=%h vy=%h mv=%b"},
                     $time, e.px, e.py, e.vx, e.vy, e.moved, out_bus.position_x,
                     out_bus.position_y, out_bus.velocity_x, out_bus.velocity_y,
                     out_bus.moved);
        end
      end
    end
  end

  task automatic write_reg(logic [odr_pkg::CFG_IDX_W-1:0] idx,
                           logic [odr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    // predictor copy follows the register map, other indexes are ignored
    if (idx == odr_pkg::CFG_DPC) dpc_q = val;
    else if (idx == odr_pkg::CFG_TR) rate_q = val[19:0];
  endtask

  // waits until every report is sent and answered, then lets the block settle
  task automatic drain();
    while (pending_reports.size() > 0 || in_bus.valid || expected_tracks.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_report(logic [31:0] st, logic [15:0] tk, logic [31:0] ct,
                            logic signed [15:0] hd, logic hv);
    report_t rp;
    rp.stamp = st;
    rp.tick = tk;
    rp.count = ct;
    rp.heading = hd;
    rp.hvalid = hv;
    pending_reports.push_back(rp);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) pending_reports.push_back(random_report());
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.timestamp = '0;
    in_bus.tick = '0;
    in_bus.pulse_count = '0;
    in_bus.heading = '0;
    in_bus.heading_valid = 1'b0;
    out_bus.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: first report with an unchanged zero stamp, then the special cases
    add_report(32'd0, 16'd0, 32'd0, 16'sd0, 1'b1);
    add_report(32'd1, 16'd0, 32'd10, 16'sd0, 1'b1);       // previous tick zero
    add_report(32'd2, 16'd500, 32'd20, 16'sd0, 1'b1);     // previous tick zero again
    add_report(32'd3, 16'd1000, 32'd120, 16'sd0, 1'b1);   // normal step east
    add_report(32'd3, 16'd1500, 32'd220, 16'sd0, 1'b1);   // same stamp
    add_report(32'd4, 16'd1500, 32'd320, 16'sd12868, 1'b1); // zero tick difference
    add_report(32'd5, 16'd2000, 32'd400, 16'sd25736, 1'b1); // heading plus pi
    add_report(32'd6, 16'd2500, 32'd480, -16'sd25736, 1'b1); // heading minus pi
    add_report(32'd7, 16'd3000, 32'd560, 16'sh7fff, 1'b1); // out of range headings
    add_report(32'd8, 16'd3500, 32'd640, 16'sh8000, 1'b1);
    add_report(32'd9, 16'd4000, 32'd700, -16'sd12868, 1'b0); // invalid heading
    add_report(32'd10, 16'hfff0, 32'd800, 16'sd6434, 1'b1);
    add_report(32'd11, 16'h0010, 32'd900, 16'sd6434, 1'b1); // tick wrap
    add_report(32'd12, 16'hffff, 32'd850, -16'sd6434, 1'b1); // count goes back
    add_report(32'hffffffff, 16'd1, 32'hffffffff, 16'sd100, 1'b1);
    add_report(32'd0, 16'd2, 32'd5, 16'sd0, 1'b1);        // count wraps
    add_report(32'd13, 16'd3, 32'h7fffffff, 16'sd0, 1'b1); // huge step
    drain();

    // extreme scale, then pause until everything answered before continuing
    write_reg(odr_pkg::CFG_DPC, 24'hffffff);
    write_reg(odr_pkg::CFG_TR, 24'd1000000);
    add_report(32'd20, 16'd10, 32'd0, 16'sd3000, 1'b1);
    add_report(32'd21, 16'd11, 32'hffffffff, 16'sd3000, 1'b1); // position saturates
    add_report(32'd22, 16'd12, 32'hfffffffe, -16'sd20000, 1'b1);
    add_report(32'd23, 16'd13, 32'hfffffffd, -16'sd20000, 1'b1);
    hold_sender = 1'b1;
    random_phase(240);
    while (expected_tracks.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
    hold_sender = 1'b0;
    drain();

    write_reg(odr_pkg::CFG_DPC, 24'd0);
    write_reg(odr_pkg::CFG_TR, 24'd1);
    idle_on = 1'b0;
    random_phase(220);
    drain();

    idle_on = 1'b1;
    write_reg(odr_pkg::CFG_DPC, 24'd13107);
    write_reg(odr_pkg::CFG_TR, 24'd0);                 // zero rate clears velocity
    write_reg(2'd2, 24'h123456);              // unmapped index
    write_reg(2'd3, 24'hffffff);
    random_phase(250);
    drain();

    write_reg(odr_pkg::CFG_DPC, 24'd1);
    write_reg(odr_pkg::CFG_TR, 24'hfffff);
    random_phase(250);
    drain();

    write_reg(odr_pkg::CFG_DPC, 24'($urandom_range(0, 24'hffffff)));
    write_reg(odr_pkg::CFG_TR, 24'($urandom_range(1, 1000000)));
    random_phase(290);
    drain();

    write_reg(odr_pkg::CFG_DPC, 24'd13107);
    write_reg(odr_pkg::CFG_TR, 24'd21736);
    random_phase(300);
    drain();

    if (mismatches == 0 && unexpected == 0 && expected_tracks.size() == 0) begin
      $display("[odometer_dead_reckoning] OK");
    end else begin
      $display("[odometer_dead_reckoning] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("[odometer_dead_reckoning] ERROR");
    $finish;
  end

endmodule
